// ===== hw/rtl/bhec_pkg.sv =====
// Package for the bloom hash edge comparator.
// Holds key constants, the CRC32C word function and the four-key sort helper.
// No dependencies.
package bhec_pkg;

  localparam int unsigned KeyCount = 4;
  localparam int unsigned KeyW = 16;
  localparam int unsigned IdW = 32;
  localparam int unsigned SetBitsW = 4;
  localparam logic [SetBitsW-1:0] SetBitsReset = 4'd1;
  localparam logic [31:0] CrcPoly = 32'h82F63B78;

  typedef logic [KeyW-1:0] key_t;
  typedef key_t [KeyCount-1:0] keys_t;

  // CRC32C update over 32 data bits, least significant first.  The upper
  // 32 bits of the zero-extended source are handled in a separate step.
  function automatic logic [31:0] crc_step32(logic [31:0] crc, logic [31:0] data);
    logic [31:0] c;
    c = crc;
    for (int n = 0; n < 32; n++) begin
      c = (c >> 1) ^ (((c[0] ^ data[n]) == 1'b1) ? CrcPoly : 32'h0);
    end
    return c;
  endfunction

  // Four-key sorting network, ascending.
  function automatic keys_t sort4(keys_t v_in);
    keys_t v;
    key_t t;
    v = v_in;
    if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
    if (v[2] > v[3]) begin t = v[2]; v[2] = v[3]; v[3] = t; end
    if (v[0] > v[2]) begin t = v[0]; v[0] = v[2]; v[2] = t; end
    if (v[1] > v[3]) begin t = v[1]; v[1] = v[3]; v[3] = t; end
    if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
    return v;
  endfunction

endpackage

// ===== hw/rtl/bhec_hash.sv =====
// Four-stage CRC32C pipeline that turns one source id into four raw keys.
// Depends on bhec_pkg.
module bhec_hash (
  input  logic                        clk_i,
  input  logic [bhec_pkg::IdW-1:0]    src_i,
  output bhec_pkg::keys_t             keys_o
);

  // Stages 1 and 2 give h1 over the low word and the zero high word.
  // Stages 3 and 4 give h2, seeded with h1, over the same two words.
  logic [31:0] c1_q, c2_q, c3_q, c4_q, h1_q, h1_late_q;
  logic [31:0] s1_q, s2_q;

  always_ff @(posedge clk_i) begin
    c1_q      <= bhec_pkg::crc_step32(32'h0, src_i);
    s1_q      <= src_i;
    c2_q      <= bhec_pkg::crc_step32(c1_q, 32'h0);
    s2_q      <= s1_q;
    c3_q      <= bhec_pkg::crc_step32(c2_q, s2_q);
    h1_q      <= c2_q;
    c4_q      <= bhec_pkg::crc_step32(c3_q, 32'h0);
    h1_late_q <= h1_q;
  end

  // Both hashes leave the last stage together.
  assign keys_o[0] = h1_late_q[15:0];
  assign keys_o[1] = h1_late_q[31:16];
  assign keys_o[2] = c4_q[15:0];
  assign keys_o[3] = c4_q[31:16];

endmodule

// ===== hw/rtl/bhec_order.sv =====
// Ordering stage: compares sorted masked keys at each prefix width from 1 to 15, up to k.
// Depends on bhec_pkg.
module bhec_order (
  input  logic                        clk_i,
  input  bhec_pkg::keys_t             ka_i,
  input  bhec_pkg::keys_t             kb_i,
  input  logic [bhec_pkg::SetBitsW-1:0] k_i,
  output logic [bhec_pkg::KeyW-1:0]   lt_o,
  output logic [bhec_pkg::KeyW-1:0]   gt_o
);

  // Per-width verdicts, registered; width w+1 uses vector bit w.
  logic [bhec_pkg::KeyW-1:0] lt_d, gt_d, lt_q, gt_q;

  always_comb begin
    bhec_pkg::keys_t ca, cb;
    logic [bhec_pkg::KeyW-1:0] m;
    logic done;
    lt_d = '0;
    gt_d = '0;
    for (int i = 1; i < bhec_pkg::KeyW; i++) begin
      m = bhec_pkg::KeyW'((32'd1 << i) - 32'd1);
      for (int j = 0; j < bhec_pkg::KeyCount; j++) begin
        ca[j] = ka_i[j] & m;
        cb[j] = kb_i[j] & m;
      end
      ca = bhec_pkg::sort4(ca);
      cb = bhec_pkg::sort4(cb);
      done = 1'b0;
      for (int j = 0; j < bhec_pkg::KeyCount; j++) begin
        if (!done && ca[j] != cb[j]) begin
          done = 1'b1;
          lt_d[i-1] = (ca[j] < cb[j]) && (i <= int'(k_i));
          gt_d[i-1] = (ca[j] > cb[j]) && (i <= int'(k_i));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lt_q <= lt_d;
    gt_q <= gt_d;
  end

  assign lt_o = lt_q;
  assign gt_o = gt_q;

endmodule

// ===== hw/rtl/bloom_hash_edge_comparator.sv =====
// Top level of the bloom hash edge comparator.
// Depends on bhec_pkg, bhec_hash and bhec_order.
//
// Usage: drive a_src_i, a_dst_i, b_src_i, b_dst_i and pulse start_i; busy_o
// is always low, so a transaction is accepted at every edge with start_i high.
// Each accepted transaction yields a_before_b_o with done_o high for exactly
// one cycle, in order. One result per cycle is sustained; the depth is set
// by the four CRC stages, the key compare stage and the final priority pick
// stage.
// set_bits_we_i/set_bits_i write the key width k; it is sampled with the
// keys at the compare stage, so write it only while the pipeline is empty.
// Reset clears all valid bits and sets k to 1. The receiver cannot stall.
module bloom_hash_edge_comparator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] a_src_i,
  input  logic [31:0] a_dst_i,
  input  logic [31:0] b_src_i,
  input  logic [31:0] b_dst_i,
  input  logic        set_bits_we_i,
  input  logic [3:0]  set_bits_i,
  output logic        done_o,
  output logic        a_before_b_o
);

  localparam int unsigned Depth = 6;

  logic [3:0] k_q;
  logic [Depth-1:0] vld_q;

  assign busy_o = 1'b0;

  // Configuration register and valid pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= bhec_pkg::SetBitsReset;
      vld_q <= '0;
    end else begin
      if (set_bits_we_i) k_q <= set_bits_i;
      vld_q <= {vld_q[Depth-2:0], start_i};
    end
  end

  // Fallback order by source then destination, delayed alongside the hash.
  logic [4:0] fb_q;
  logic fb_d;
  assign fb_d = (a_src_i != b_src_i) ? (a_src_i < b_src_i) : (a_dst_i < b_dst_i);
  always_ff @(posedge clk_i) fb_q <= {fb_q[3:0], fb_d};

  bhec_pkg::keys_t ka, kb, kam, kbm;
  bhec_hash u_ha (.clk_i, .src_i(a_src_i), .keys_o(ka));
  bhec_hash u_hb (.clk_i, .src_i(b_src_i), .keys_o(kb));

  // Mask the raw keys to k bits.
  logic [15:0] km;
  assign km = 16'((32'd1 << k_q) - 32'd1);
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      kam[j] = ka[j] & km;
      kbm[j] = kb[j] & km;
    end
  end

  logic [15:0] lt, gt;
  bhec_order u_ord (.clk_i, .ka_i(kam), .kb_i(kbm), .k_i(k_q), .lt_o(lt), .gt_o(gt));

  // Pick the smallest width that decides.
  logic res_q;
  always_ff @(posedge clk_i) begin
    logic r, d;
    r = fb_q[4];
    d = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (!d && (lt[i] || gt[i])) begin
        d = 1'b1;
        r = lt[i];
      end
    end
    res_q <= r;
  end

  assign done_o = vld_q[Depth-1];
  assign a_before_b_o = res_q;

  // Every result follows an accepted start.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Depth)) else $error("result without start");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(|(lt & gt))) else $error("width both lt and gt");

endmodule

// ===== tb/bloom_hash_edge_comparator_test.sv =====
// Self-checking testbench for the bloom hash edge comparator.
// It predicts each ordering decision from the CRC32C keys of the sources.
// It depends on bhec_pkg and the bloom_hash_edge_comparator RTL.
module bloom_hash_edge_comparator_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard that predicts edge order and checks each decision in order.
  class edge_order_board;
    bit expected_order[$];
    logic [bhec_pkg::SetBitsW-1:0] key_width;
    int errors;
    int checked;

    function new();
      key_width = bhec_pkg::SetBitsReset;
      errors = 0;
      checked = 0;
    endfunction

    // CRC32C over the source zero-extended to 64 bits, low bit first.
    function automatic logic [31:0] crc64(logic [31:0] seed, logic [31:0] id);
      logic [31:0] c;
      logic [63:0] word;
      c = seed;
      word = {32'h0, id};
      for (int n = 0; n < 64; n++) begin
        c = (c >> 1) ^ ((c[0] ^ word[n]) ? 32'h82F63B78 : 32'h0);
      end
      return c;
    endfunction

    function automatic void source_keys(logic [31:0] id, output int unsigned k[4]);
      logic [31:0] h1;
      logic [31:0] h2;
      int unsigned m;
      h1 = crc64(32'h0, id);
      h2 = crc64(h1, id);
      m = (1 << key_width) - 1;
      k[0] = h1[15:0] & m;
      k[1] = h1[31:16] & m;
      k[2] = h2[15:0] & m;
      k[3] = h2[31:16] & m;
    endfunction

    function automatic void sort_keys(ref int unsigned v[4]);
      int unsigned t;
      for (int p = 0; p < 3; p++) begin
        for (int q = 0; q < 3 - p; q++) begin
          if (v[q] > v[q+1]) begin
            t = v[q];
            v[q] = v[q+1];
            v[q+1] = t;
          end
        end
      end
    endfunction

    // Note an accepted transaction and queue its expected decision.
    function void note_pair(logic [31:0] as, logic [31:0] ad, logic [31:0] bs,
                            logic [31:0] bd);
      int unsigned ka[4];
      int unsigned kb[4];
      int unsigned ca[4];
      int unsigned cb[4];
      int decided;
      bit verdict;
      source_keys(as, ka);
      source_keys(bs, kb);
      decided = 0;
      verdict = 0;
      for (int w = 1; w <= key_width && !decided; w++) begin
        for (int j = 0; j < 4; j++) begin
          ca[j] = ka[j] & ((1 << w) - 1);
          cb[j] = kb[j] & ((1 << w) - 1);
        end
        sort_keys(ca);
        sort_keys(cb);
        for (int j = 0; j < 4 && !decided; j++) begin
          if (ca[j] != cb[j]) begin
            decided = 1;
            verdict = ca[j] < cb[j];
          end
        end
      end
      if (!decided) verdict = (as != bs) ? (as < bs) : (ad < bd);
      expected_order.push_back(verdict);
    endfunction

    // Check one decision against the oldest prediction.
    function void check_order(logic actual);
      bit want;
      checked++;
      if (expected_order.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual a_before_b=%0b", $time, actual);
        return;
      end
      want = expected_order.pop_front();
      if (actual !== want) begin
        errors++;
        $display("%0t: a_before_b mismatch, expected %0b actual %0b", $time, want, actual);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic [31:0] a_src_i;
  logic [31:0] a_dst_i;
  logic [31:0] b_src_i;
  logic [31:0] b_dst_i;
  logic set_bits_we_i;
  logic [3:0] set_bits_i;
  logic done_o;
  logic a_before_b_o;

  edge_order_board board;
  int idle_cycles;
  int pairs_sent;

  bloom_hash_edge_comparator uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .a_src_i(a_src_i),
    .a_dst_i(a_dst_i),
    .b_src_i(b_src_i),
    .b_dst_i(b_dst_i),
    .set_bits_we_i(set_bits_we_i),
    .set_bits_i(set_bits_i),
    .done_o(done_o),
    .a_before_b_o(a_before_b_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Monitor: note accepted transactions, check results, and run the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        board.note_pair(a_src_i, a_dst_i, b_src_i, b_dst_i);
        pairs_sent++;
      end
      if (done_o) board.check_order(a_before_b_o);
      if ((start_i && !busy_o) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("Watchdog expired with %0d results outstanding.",
                 board.expected_order.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // Present one transaction and hold it until it is accepted.
  task automatic send_pair(logic [31:0] as, logic [31:0] ad, logic [31:0] bs,
                           logic [31:0] bd);
    a_src_i <= as;
    a_dst_i <= ad;
    b_src_i <= bs;
    b_dst_i <= bd;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Idle the sender; start is lowered only when a gap follows.
  task automatic pause_sender(int unsigned n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Wait for the pipeline to empty, then write the key width.
  task automatic write_key_width(logic [3:0] k);
    start_i <= 1'b0;
    while (board.expected_order.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    set_bits_i <= k;
    set_bits_we_i <= 1'b1;
    @(negedge clk_i);
    set_bits_we_i <= 1'b0;
    board.key_width = k;
  endtask

  task automatic random_phase(int count);
    logic [31:0] as;
    logic [31:0] bs;
    for (int n = 0; n < count; n++) begin
      as = pick_id();
      bs = ($urandom_range(0, 4) == 0) ? as : pick_id();
      send_pair(as, pick_id(), bs, ($urandom_range(0, 7) == 0) ? 32'h0 : pick_id());
      pause_sender((n % 100 < 30) ? 0 : gap_len());
    end
  endtask

  initial begin
    logic [3:0] widths[6];
    board = new();
    idle_cycles = 0;
    pairs_sent = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    a_src_i = '0;
    a_dst_i = '0;
    b_src_i = '0;
    b_dst_i = '0;
    set_bits_we_i = 1'b0;
    set_bits_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed cases at the reset key width: equal edges, extremes, tie on source.
    send_pair(32'h0, 32'h0, 32'h0, 32'h0);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_pair(32'h5, 32'h1, 32'h5, 32'h2);
    send_pair(32'h5, 32'h2, 32'h5, 32'h1);
    pause_sender(1);

    // Zero key width: order by source, then destination alone.
    write_key_width(4'd0);
    send_pair(32'h1, 32'h9, 32'h2, 32'h0);
    send_pair(32'h2, 32'h0, 32'h1, 32'h9);
    send_pair(32'h7, 32'h3, 32'h7, 32'h3);
    send_pair(32'h7, 32'h3, 32'h7, 32'h4);
    send_pair(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);

    // Widest key width with extreme and walking-bit values.
    write_key_width(4'd15);
    send_pair(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
    send_pair(32'h8000_0000, 32'h1, 32'h1, 32'h8000_0000);
    send_pair(32'h1234_5678, 32'h10, 32'h1234_5678, 32'h20);
    pause_sender(1);

    // Random phases across several key widths, extremes included.
    widths = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'($urandom_range(0, 15))};
    foreach (widths[w]) begin
      write_key_width(widths[w]);
      random_phase(165);
    end

    start_i <= 1'b0;
    while (board.expected_order.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("Sent %0d edge pairs over key widths 0 to 15 and checked %0d decisions.",
             pairs_sent, board.checked);
    if (board.errors == 0 && board.expected_order.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/bhec_pkg.sv
hw/rtl/bhec_hash.sv
hw/rtl/bhec_order.sv
hw/rtl/bloom_hash_edge_comparator.sv
tb/bloom_hash_edge_comparator_test.sv
